// ===== rtl/spwr_pkg.sv =====
package spwr_pkg;

    // character codes
    localparam logic [7:0] ChBsl   = 8'h5C;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChQuest = 8'h3F;
    localparam logic [7:0] ChU     = 8'h55;
    localparam logic [7:0] ChN     = 8'h4E;
    localparam logic [7:0] ChC     = 8'h43;

    // head window and prefix lengths
    localparam int HeadLen = 6;
    localparam logic [2:0] PrefixShortLen = 3'd4;
    localparam logic [2:0] PrefixUncLen   = 3'd6;

    // default depth of the command queue
    localparam int CmdDepthDefault = 4;

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_SKIP,
        PH_LETTER,
        PH_PASS
    } phase_t;

    typedef enum logic {
        CMD_BYTES,
        CMD_PREFIX
    } cmd_kind_t;

    // one request from the front to the back
    typedef struct packed {
        cmd_kind_t  kind;
        logic       unc;     // prefix is \\UNC\ (prefix requests only)
        logic [7:0] byte0;   // bytes: first byte; prefix: third character
        logic [7:0] byte1;
        logic [1:0] count;   // number of bytes (byte requests only)
        logic       last;    // path ends after this request
    } cmd_t;

    typedef struct packed {
        phase_t     next;
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } feed_t;

    function automatic logic is_sep(input logic [7:0] b);
        return (b == ChSlash) || (b == ChBsl);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_bsl(input logic [7:0] b);
        return (b == ChSlash) ? ChBsl : b;
    endfunction

    // stream rules for one path byte after the prefix
    function automatic feed_t feed(input phase_t ph, input logic [7:0] b);
        feed_t f;
        f.next  = PH_PASS;
        f.count = 2'd1;
        f.byte0 = to_bsl(b);
        f.byte1 = ChBsl;
        unique case (ph) inside
            PH_SKIP:
            begin
                if (is_sep(b))
                begin
                    f.next  = PH_SKIP;
                    f.count = 2'd0;
                end
                else
                begin
                    f.byte0 = b;
                    f.next  = is_letter(b) ? PH_LETTER : PH_PASS;
                end
            end
            PH_LETTER:
            begin
                if (is_sep(b))
                begin
                    f.count = 2'd2;
                    f.byte0 = ChColon;
                end
                else
                begin
                    f.byte0 = b;
                end
            end
            PH_PASS, PH_COLLECT:
            begin
                f.next = PH_PASS;
            end
            default:
            begin
                f.next = PH_PASS;
            end
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/spwr_cmd_fifo.sv =====
module spwr_cmd_fifo
    import spwr_pkg::*;
#(
    parameter int DEPTH = CmdDepthDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t rdata,
    output logic empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    cmd_t            mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntFull);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/spwr_front.sv =====
module spwr_front
    import spwr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] path_byte,
    input  logic       end_of_path,
    input  logic       push,
    output logic       full,
    output logic       q_push,
    output cmd_t       q_cmd,
    input  logic       q_full
);

    logic [7:0] head_reg [HeadLen];
    phase_t     phase_reg, phase_next;
    logic [2:0] count_reg, count_next;
    logic       replay_reg, replay_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] len_reg, len_next;
    logic       end_reg, end_next;

    logic       accept;
    logic       head_we;
    logic [2:0] new_len;
    logic [7:0] nb [HeadLen];
    logic       two_sep, ns4, ns6, rep_final;
    feed_t      f;

    assign full   = replay_reg || q_full;
    assign accept = push && !full;
    assign new_len = count_reg + 3'd1;

    // head window as seen at the decision: incoming byte merged, tail zeroed
    always_comb
    begin
        for (int i = 0; i < HeadLen; i++)
        begin
            if (3'(i) == count_reg)
            begin
                nb[i] = to_bsl(path_byte);
            end
            else if (3'(i) < count_reg)
            begin
                nb[i] = to_bsl(head_reg[i]);
            end
            else
            begin
                nb[i] = 8'h00;
            end
        end
        two_sep = (nb[0] == ChBsl) && (nb[1] == ChBsl);
        ns4 = two_sep && ((nb[2] == ChDot) || (nb[2] == ChQuest)) && (nb[3] == ChBsl);
        ns6 = two_sep && (nb[2] == ChU) && (nb[3] == ChN) && (nb[4] == ChC)
              && (nb[5] == ChBsl);
    end

    // request generation and phase control
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        replay_next = replay_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        end_next    = end_reg;
        head_we     = 1'b0;
        q_push      = 1'b0;
        q_cmd.kind  = CMD_BYTES;
        q_cmd.unc   = 1'b0;
        q_cmd.byte0 = 8'h00;
        q_cmd.byte1 = 8'h00;
        q_cmd.count = 2'd0;
        q_cmd.last  = 1'b0;
        rep_final   = ((idx_reg + 3'd1) == len_reg);
        f           = feed(phase_reg, replay_reg ? head_reg[idx_reg] : path_byte);

        if (replay_reg)
        begin
            // head bytes left after the prefix, one per cycle while the queue has room
            if (!q_full)
            begin
                q_push      = 1'b1;
                q_cmd.byte0 = f.byte0;
                q_cmd.byte1 = f.byte1;
                q_cmd.count = f.count;
                q_cmd.last  = rep_final && end_reg;
                idx_next    = idx_reg + 3'd1;
                phase_next  = f.next;
                if (rep_final)
                begin
                    replay_next = 1'b0;
                    if (end_reg)
                    begin
                        phase_next = PH_COLLECT;
                    end
                end
            end
        end
        else if (accept)
        begin
            if (phase_reg == PH_COLLECT)
            begin
                head_we = 1'b1;
                if ((new_len == 3'(HeadLen)) || end_of_path)
                begin
                    // prefix decision
                    count_next  = 3'd0;
                    q_push      = 1'b1;
                    q_cmd.kind  = CMD_PREFIX;
                    q_cmd.unc   = ns6 || (!ns4 && two_sep);
                    q_cmd.byte0 = ns4 ? nb[2] : ChQuest;
                    idx_next    = ns4 ? PrefixShortLen : 3'd0;
                    len_next    = new_len;
                    end_next    = end_of_path;
                    phase_next  = PH_SKIP;
                    if (!ns6 && !(ns4 && (new_len == PrefixShortLen)))
                    begin
                        replay_next = 1'b1;
                    end
                    else
                    begin
                        q_cmd.last = end_of_path;
                        if (end_of_path)
                        begin
                            phase_next = PH_COLLECT;
                        end
                    end
                end
                else
                begin
                    count_next = new_len;
                end
            end
            else
            begin
                // streaming byte
                q_push      = 1'b1;
                q_cmd.byte0 = f.byte0;
                q_cmd.byte1 = f.byte1;
                q_cmd.count = f.count;
                q_cmd.last  = end_of_path;
                phase_next  = end_of_path ? PH_COLLECT : f.next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COLLECT;
            count_reg  <= 3'd0;
            replay_reg <= 1'b0;
            idx_reg    <= 3'd0;
            len_reg    <= 3'd0;
            end_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            replay_reg <= replay_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            end_reg    <= end_next;
        end
    end

    // head bytes
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_reg[count_reg] <= path_byte;
        end
    end

    // replay stays inside the collected head
    assert property (@(posedge clk) disable iff (!rst_n)
        replay_reg |-> (idx_reg < len_reg))
        else $error("replay index beyond head length");

    // head count never reaches the window size while collecting
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < 3'(HeadLen))
        else $error("head count overflow");

    // a replay always ends before the next input is taken in collect phase
    assert property (@(posedge clk) disable iff (!rst_n)
        replay_reg |-> (phase_reg != PH_COLLECT))
        else $error("replay running in collect phase");

endmodule

// ===== rtl/spwr_back.sv =====
module spwr_back
    import spwr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       q_cmd,
    input  logic       q_empty,
    output logic       q_pop,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       empty,
    input  logic       pop
);

    logic [2:0] idx_reg, idx_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic [2:0] n_bytes;
    logic [7:0] step_byte;
    logic       is_flush, no_step, emits, out_free, step_fire, step_done;

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;
    assign out_free = !out_valid_reg || pop;

    // byte at the current step of the request
    always_comb
    begin
        if (q_cmd.kind == CMD_PREFIX)
        begin
            n_bytes = q_cmd.unc ? PrefixUncLen : PrefixShortLen;
            case (idx_reg)
                3'd2:    step_byte = q_cmd.unc ? ChU : q_cmd.byte0;
                3'd3:    step_byte = q_cmd.unc ? ChN : ChBsl;
                3'd4:    step_byte = ChC;
                default: step_byte = ChBsl;
            endcase
        end
        else
        begin
            n_bytes   = {1'b0, q_cmd.count};
            step_byte = (idx_reg == 3'd0) ? q_cmd.byte0 : q_cmd.byte1;
        end
    end

    // step sequencing with one held byte
    always_comb
    begin
        is_flush  = (idx_reg == n_bytes);
        no_step   = is_flush && !q_cmd.last;
        emits     = is_flush || held_valid_reg;
        step_fire = !q_empty && !no_step && (!emits || out_free);
        step_done = is_flush || (((idx_reg + 3'd1) == n_bytes) && !q_cmd.last);
        q_pop     = !q_empty && (no_step || (step_fire && step_done));

        idx_next        = idx_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        if (q_pop)
        begin
            idx_next = 3'd0;
        end
        else if (step_fire)
        begin
            idx_next = idx_reg + 3'd1;
        end

        if (step_fire)
        begin
            if (emits)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = held_byte_reg;
                out_last_next  = is_flush;
            end
            if (is_flush)
            begin
                held_valid_next = 1'b0;
            end
            else
            begin
                held_valid_next = 1'b1;
                held_byte_next  = step_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= 3'd0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    // a path end always finds a held byte to close it
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && is_flush) |-> held_valid_reg)
        else $error("path end with no held byte");

    // no output register overwrite while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && emits) |-> out_free)
        else $error("output register overwritten");

    // after a closing byte the hold stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && is_flush) |=> !held_valid_reg)
        else $error("held byte kept past path end");

endmodule

// ===== rtl/shell_to_windows_path_rewriter.sv =====
// channel   direction  handshake             payload
// input     in         push / full           path_byte[7:0], end_of_path
// result    out        pop / empty           out_byte[7:0], out_last
//
// Unless a side stalls, streaming bytes move one per cycle; a letter followed by a
// separator gives two output bytes. At the prefix decision the input stalls while
// the head bytes after the prefix are replayed, one per cycle while the queue has
// room; the back end emits the four or six prefix bytes at most one per cycle.
// Reset (rst_n low, asynchronous) empties the queue, the hold stage and the output.
// Either side may stall; the request queue and the output register decouple them.
module shell_to_windows_path_rewriter
    import spwr_pkg::*;
#(
    parameter int CMD_DEPTH = CmdDepthDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] path_byte,
    input  logic       end_of_path,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       empty,
    input  logic       pop
);

    cmd_t wr_cmd, rd_cmd;
    logic wr_push, q_full, q_empty, q_pop;

    // classify bytes and decide the prefix
    spwr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .path_byte   (path_byte),
        .end_of_path (end_of_path),
        .push        (push),
        .full        (full),
        .q_push      (wr_push),
        .q_cmd       (wr_cmd),
        .q_full      (q_full)
    );

    // request queue between front and back
    spwr_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (wr_push),
        .wdata (wr_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (rd_cmd),
        .empty (q_empty)
    );

    // expand requests into output bytes
    spwr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (rd_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .out_byte (out_byte),
        .out_last (out_last),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

// ===== verif/shell_to_windows_path_rewriter_tb.sv =====
`timescale 1ns / 1ps

module shell_to_windows_path_rewriter_tb;
    import spwr_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } win_char_t;

    typedef struct {
        logic [7:0] ch;
        logic       eop;
        int         row;
    } path_req_t;

    localparam int DirRows   = 7;
    localparam int RandReqs  = 450;
    localparam int DrainWait = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] path_byte = 8'h00;
    logic       end_of_path = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] out_byte;
    logic       out_last;
    logic       empty;
    logic       pop = 1'b0;

    shell_to_windows_path_rewriter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .path_byte   (path_byte),
        .end_of_path (end_of_path),
        .push        (push),
        .full        (full),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .empty       (empty),
        .pop         (pop)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // request stream and directed table
    path_req_t  path_reqs[$];
    string      dir_path[DirRows];
    string      dir_want[DirRows];
    logic [7:0] pth[$];
    int         req_idx = 0;
    int         want_pos = 0;
    int         err_cnt = 0;
    bit         calm;

    // expected translated characters, oldest first
    win_char_t  win_path_q[$];
    win_char_t  step_out[$];

    // rewriter state
    logic [7:0] head_q[HeadLen];
    int         head_n = 0;
    phase_t     ph = PH_COLLECT;
    logic [7:0] hold_ch = 8'h00;
    bit         hold_v = 1'b0;

    function automatic bit is_separator(input logic [7:0] b);
        return (b == ChSlash) || (b == ChBsl);
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    // newest character waits until the next one is known
    function automatic void put_char(input logic [7:0] b);
        if (hold_v)
            step_out.push_back('{ch: hold_ch, last: 1'b0});
        hold_ch = b;
        hold_v  = 1'b1;
    endfunction

    // stream rules after the prefix
    function automatic void stream_byte(input logic [7:0] b);
        case (ph)
            PH_SKIP:
            begin
                if (!is_separator(b))
                begin
                    put_char(b);
                    ph = is_alpha(b) ? PH_LETTER : PH_PASS;
                end
            end
            PH_LETTER:
            begin
                if (is_separator(b))
                begin
                    put_char(ChColon);
                    put_char(ChBsl);
                end
                else
                    put_char(b);
                ph = PH_PASS;
            end
            default:
            begin
                put_char((b == ChSlash) ? ChBsl : b);
                ph = PH_PASS;
            end
        endcase
    endfunction

    // pick the namespace prefix from the head, then replay the rest of the head
    function automatic void choose_prefix(input int len);
        logic [7:0] nb[HeadLen];
        logic [7:0] b;
        int         ns;
        bit         two_sep;
        ns = 0;
        for (int i = 0; i < HeadLen; i++)
        begin
            b = (i < len) ? head_q[i] : 8'h00;
            nb[i] = (b == ChSlash) ? ChBsl : b;
        end
        two_sep = (nb[0] == ChBsl) && (nb[1] == ChBsl);
        if (two_sep && (nb[2] == ChDot || nb[2] == ChQuest) && nb[3] == ChBsl)
            ns = PrefixShortLen;
        else if (two_sep && nb[2] == ChU && nb[3] == ChN && nb[4] == ChC && nb[5] == ChBsl)
            ns = PrefixUncLen;
        if (ns != 0)
        begin
            for (int i = 0; i < ns; i++)
                put_char(nb[i]);
        end
        else if (two_sep)
        begin
            put_char(ChBsl);
            put_char(ChBsl);
            put_char(ChU);
            put_char(ChN);
            put_char(ChC);
            put_char(ChBsl);
        end
        else
        begin
            put_char(ChBsl);
            put_char(ChBsl);
            put_char(ChQuest);
            put_char(ChBsl);
        end
        ph = PH_SKIP;
        for (int i = ns; i < len; i++)
            stream_byte(head_q[i]);
    endfunction

    // one path byte in, translated characters into step_out
    function automatic void rewrite_byte(input logic [7:0] b, input logic eop);
        step_out.delete();
        if (ph == PH_COLLECT)
        begin
            if (head_n < HeadLen)
            begin
                head_q[head_n] = b;
                head_n++;
            end
            if (head_n >= HeadLen || eop)
            begin
                choose_prefix(head_n);
                head_n = 0;
            end
        end
        else
            stream_byte(b);
        if (eop)
        begin
            if (hold_v)
                step_out.push_back('{ch: hold_ch, last: 1'b1});
            hold_v = 1'b0;
            head_n = 0;
            ph = PH_COLLECT;
        end
    endfunction

    // random path pieces
    function automatic logic [7:0] sep_char();
        return $urandom_range(0, 1) ? ChSlash : ChBsl;
    endfunction

    function automatic logic [7:0] alpha_char();
        return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("a", "z"));
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 15);
        if (r < 8)
            return alpha_char();
        else if (r == 8)
            return 8'($urandom_range("0", "9"));
        else if (r == 9)
            return ChDot;
        else if (r == 10)
            return ChQuest;
        else if (r == 11)
            return sep_char();
        else if (r == 12)
            return $urandom_range(0, 1) ? ChU : ($urandom_range(0, 1) ? ChN : ChC);
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void add_name();
        repeat ($urandom_range(1, 4))
            pth.push_back(rand_char());
    endfunction

    function automatic void add_tail();
        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(1, 2))
                pth.push_back(sep_char());
            add_name();
        end
    endfunction

    function automatic void add_ns_prefix();
        pth.push_back(sep_char());
        pth.push_back(sep_char());
        if ($urandom_range(0, 2) == 0)
        begin
            pth.push_back(ChU);
            pth.push_back(ChN);
            pth.push_back(ChC);
        end
        else
            pth.push_back($urandom_range(0, 1) ? ChDot : ChQuest);
        pth.push_back(sep_char());
    endfunction

    // mostly well-formed paths with random content, some broken ones and noise
    function automatic void make_random_path();
        int cut;
        pth.delete();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                add_ns_prefix();
                add_tail();
            end
            2:
            begin
                pth.push_back(sep_char());
                pth.push_back(sep_char());
                if ($urandom_range(0, 1))
                    pth.push_back(alpha_char());
                else
                    add_name();
                pth.push_back(sep_char());
                add_tail();
            end
            3:
            begin
                repeat ($urandom_range(0, 2))
                    pth.push_back(sep_char());
                pth.push_back(alpha_char());
                if ($urandom_range(0, 3) != 0)
                    pth.push_back(sep_char());
                add_tail();
            end
            4:
            begin
                add_name();
                add_tail();
            end
            5:
            begin
                repeat ($urandom_range(1, 5))
                    pth.push_back(rand_char());
            end
            6:
            begin
                repeat ($urandom_range(1, 8))
                    pth.push_back(8'($urandom_range(1, 255)));
            end
            7:
            begin
                // broken prefix: cut short or one character spoiled
                add_ns_prefix();
                if ($urandom_range(0, 1))
                begin
                    cut = $urandom_range(1, pth.size() - 1);
                    while (pth.size() > cut)
                        void'(pth.pop_back());
                end
                else
                begin
                    pth[$urandom_range(0, pth.size() - 1)] = rand_char();
                    add_tail();
                end
            end
            8:
            begin
                repeat ($urandom_range(3, 7))
                    pth.push_back(sep_char());
                add_tail();
            end
            default:
            begin
                pth.push_back(sep_char());
                pth.push_back(alpha_char());
                if ($urandom_range(0, 1))
                    pth.push_back(sep_char());
            end
        endcase
    endfunction

    function automatic void queue_path(input int row);
        for (int i = 0; i < pth.size(); i++)
            path_reqs.push_back('{ch: pth[i], eop: (i == pth.size() - 1), row: row});
    endfunction

    // stimulus build, reset, end of run
    initial
    begin
        string s;
        dir_path = '{"a", "//./x", "/\\UNC/", "//", "/c/", "\001\377", "//a/s"};
        dir_want = '{"\\\\?\\a", "\\\\.\\x", "\\\\UNC\\", "\\\\UNC\\", "\\\\?\\c:\\", "",
                     "\\\\UNC\\a:\\s"};
        for (int r = 0; r < DirRows; r++)
        begin
            s = dir_path[r];
            pth.delete();
            for (int i = 0; i < s.len(); i++)
                pth.push_back(s[i]);
            queue_path(r);
        end
        while (path_reqs.size() < RandReqs + 24)
        begin
            make_random_path();
            queue_path(-1);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!(req_idx == path_reqs.size() && win_path_q.size() == 0))
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    assign calm = (req_idx >= 150) && (req_idx < 260);

    // request side, result check and random idling
    always @(posedge clk)
    begin
        string want;
        if (rst_n)
        begin
            // accepted path byte: work out its translated characters
            if (push && !full)
            begin
                rewrite_byte(path_reqs[req_idx].ch, path_reqs[req_idx].eop);
                want = (path_reqs[req_idx].row >= 0) ? dir_want[path_reqs[req_idx].row] : "";
                if (want.len() == 0)
                begin
                    foreach (step_out[i])
                        win_path_q.push_back(step_out[i]);
                end
                else
                begin
                    foreach (step_out[i])
                    begin
                        win_path_q.push_back('{ch: (want_pos < want.len()) ? want[want_pos] : 8'h00,
                                               last: (want_pos == want.len() - 1)});
                        want_pos++;
                    end
                    if (path_reqs[req_idx].eop)
                    begin
                        if (want_pos != want.len())
                        begin
                            $display("%0t: path length expected %0d got %0d", $time,
                                     want.len(), want_pos);
                            err_cnt++;
                        end
                        want_pos = 0;
                    end
                end
                req_idx++;
            end

            // accepted result against the oldest expectation
            if (pop && !empty)
            begin
                if (win_path_q.size() == 0)
                begin
                    $display("%0t: out_byte expected none got %h", $time, out_byte);
                    err_cnt++;
                end
                else
                begin
                    if (out_byte !== win_path_q[0].ch)
                    begin
                        $display("%0t: out_byte expected %h got %h", $time,
                                 win_path_q[0].ch, out_byte);
                        err_cnt++;
                    end
                    if (out_last !== win_path_q[0].last)
                    begin
                        $display("%0t: out_last expected %b got %b", $time,
                                 win_path_q[0].last, out_last);
                        err_cnt++;
                    end
                    void'(win_path_q.pop_front());
                end
            end

            // next request, held while full
            if (!(push && full))
            begin
                if (req_idx < path_reqs.size() && (calm || $urandom_range(0, 99) >= 31))
                begin
                    push        <= 1'b1;
                    path_byte   <= path_reqs[req_idx].ch;
                    end_of_path <= path_reqs[req_idx].eop;
                end
                else
                    push <= 1'b0;
            end
            pop <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

endmodule

// ===== files.f =====
rtl/spwr_pkg.sv
rtl/spwr_cmd_fifo.sv
rtl/spwr_front.sv
rtl/spwr_back.sv
rtl/shell_to_windows_path_rewriter.sv
verif/shell_to_windows_path_rewriter_tb.sv
